[hdl/scc_pkg.sv]
// Shared types and constants of the segment contact checker.
// No dependencies; used by scc_normal_unit and scc_pipe.
package scc_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

    // margin test: 100 * dist < 99 * radius
    localparam int MARGIN_NUM = 99;
    localparam int MARGIN_DEN = 100;

    // normal sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DLX,
        ST_DIVX,
        ST_DLY,
        ST_DIVY
    } nrm_state_t;

endpackage

[hdl/scc_normal_unit.sv]
// Segment registers and the multi-cycle unit that derives midpoint and unit normal.
// Depends on scc_pkg (register indexes, state type).
module scc_normal_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    output logic                          busy,
    output logic                          seg_zero,
    output logic signed [COORD_WIDTH-1:0] sx,
    output logic signed [COORD_WIDTH-1:0] sy,
    output logic signed [COORD_WIDTH-1:0] ex,
    output logic signed [COORD_WIDTH-1:0] ey,
    output logic signed [COORD_WIDTH-1:0] mx,
    output logic signed [COORD_WIDTH-1:0] my,
    output logic signed [FRAC_BITS+2:0]   nx,
    output logic signed [FRAC_BITS+2:0]   ny
);
    localparam int CW   = COORD_WIDTH;
    localparam int MW   = (CW + 1 > 31) ? CW + 1 : 31;
    localparam int NW   = FRAC_BITS + 32;
    localparam int NW2  = FRAC_BITS + 3;
    localparam int CNTW = $clog2(NW);

    scc_pkg::nrm_state_t state_reg, state_next;

    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg, mx_reg, my_reg;
    logic [MW-1:0]        ux_reg, uy_reg;
    logic                 dxneg_reg, dypos_reg, zero_reg;
    logic [61:0]          v_reg, res_reg, bit_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [32:0]          rem_reg;
    logic [NW-1:0]        num_reg, q_reg;
    logic signed [NW2-1:0] nx_reg, ny_reg;

    logic signed [CW:0] dx, dy;
    logic [MW-1:0]      big;
    logic [59:0]        sq_x, sq_y;
    logic [61:0]        sq_sum, sq_try;
    logic [32:0]        rem_sh;
    logic [31:0]        den;
    logic               qbit;
    logic [NW-1:0]      qn;
    logic [NW2-1:0]     qmag;

    always_comb
    begin
        dx     = {ex_reg[CW-1], ex_reg} - {sx_reg[CW-1], sx_reg};
        dy     = {ey_reg[CW-1], ey_reg} - {sy_reg[CW-1], sy_reg};
        big    = (ux_reg > uy_reg) ? ux_reg : uy_reg;
        sq_x   = ux_reg[29:0] * ux_reg[29:0];
        sq_y   = uy_reg[29:0] * uy_reg[29:0];
        sq_sum = 62'(sq_x) + 62'(sq_y);
        sq_try = res_reg + bit_reg;
        den    = {res_reg[30:0], 1'b0};
        rem_sh = {rem_reg[31:0], num_reg[NW-1]};
        qbit   = (rem_sh >= {1'b0, den});
        qn     = {q_reg[NW-2:0], qbit};
        qmag   = {1'b0, qn[NW2-2:0]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE: state_next = scc_pkg::ST_IDLE;
            scc_pkg::ST_LOAD: state_next = (dx == '0 && dy == '0) ? scc_pkg::ST_IDLE
                                                                  : scc_pkg::ST_NORM;
            scc_pkg::ST_NORM:
            begin
                if (big[MW-1:30] == '0 && big[29])
                    state_next = scc_pkg::ST_SQ;
            end
            scc_pkg::ST_SQ:   state_next = scc_pkg::ST_SQRT;
            scc_pkg::ST_SQRT: if (cnt_reg == '0) state_next = scc_pkg::ST_DLX;
            scc_pkg::ST_DLX:  state_next = scc_pkg::ST_DIVX;
            scc_pkg::ST_DIVX: if (cnt_reg == '0) state_next = scc_pkg::ST_DLY;
            scc_pkg::ST_DLY:  state_next = scc_pkg::ST_DIVY;
            scc_pkg::ST_DIVY: if (cnt_reg == '0) state_next = scc_pkg::ST_IDLE;
            default:          state_next = scc_pkg::ST_LOAD;
        endcase
        if (cfg_we)
            state_next = scc_pkg::ST_LOAD;
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != scc_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_LOAD;
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_reg    <= CW'(1) << FRAC_BITS;
            ey_reg    <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    scc_pkg::REG_START_X: sx_reg <= cfg_data;
                    scc_pkg::REG_START_Y: sy_reg <= cfg_data;
                    scc_pkg::REG_END_X:   ex_reg <= cfg_data;
                    scc_pkg::REG_END_Y:   ey_reg <= cfg_data;
                    default:              sx_reg <= sx_reg;
                endcase
            end
            if (state_reg == scc_pkg::ST_LOAD)
                zero_reg <= (dx == '0 && dy == '0);
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            scc_pkg::ST_LOAD:
            begin
                mx_reg    <= CW'(($signed({sx_reg[CW-1], sx_reg}) +
                                  $signed({ex_reg[CW-1], ex_reg})) >>> 1);
                my_reg    <= CW'(($signed({sy_reg[CW-1], sy_reg}) +
                                  $signed({ey_reg[CW-1], ey_reg})) >>> 1);
                ux_reg    <= MW'(dy[CW] ? -dy : dy);
                uy_reg    <= MW'(dx[CW] ? -dx : dx);
                dxneg_reg <= dx[CW];
                dypos_reg <= !dy[CW] && (dy != '0);
            end
            scc_pkg::ST_NORM:
            begin
                // right shifts truncate each component on its own
                if (big[MW-1:30] != '0)
                begin
                    ux_reg <= ux_reg >> 1;
                    uy_reg <= uy_reg >> 1;
                end
                else if (!big[29])
                begin
                    ux_reg <= ux_reg << 1;
                    uy_reg <= uy_reg << 1;
                end
            end
            scc_pkg::ST_SQ:
            begin
                v_reg   <= sq_sum;
                res_reg <= '0;
                bit_reg <= 62'd1 << 60;
                cnt_reg <= CNTW'(30);
            end
            scc_pkg::ST_SQRT:
            begin
                if (v_reg >= sq_try)
                begin
                    v_reg   <= v_reg - sq_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
            scc_pkg::ST_DLX, scc_pkg::ST_DLY:
            begin
                // 2 * (m << FRAC_BITS) + len, rounds half away from zero
                num_reg <= {1'b0,
                            (state_reg == scc_pkg::ST_DLX) ? ux_reg[29:0] : uy_reg[29:0],
                            FRAC_BITS'(0), 1'b0} + NW'(res_reg[30:0]);
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= CNTW'(NW - 1);
            end
            scc_pkg::ST_DIVX, scc_pkg::ST_DIVY:
            begin
                rem_reg <= qbit ? (rem_sh - {1'b0, den}) : rem_sh;
                num_reg <= num_reg << 1;
                q_reg   <= qn;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == scc_pkg::ST_DIVX)
                        nx_reg <= dypos_reg ? -$signed(qmag) : $signed(qmag);
                    else
                        ny_reg <= dxneg_reg ? -$signed(qmag) : $signed(qmag);
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign seg_zero = zero_reg;
    assign sx = sx_reg;
    assign sy = sy_reg;
    assign ex = ex_reg;
    assign ey = ey_reg;
    assign mx = mx_reg;
    assign my = my_reg;
    assign nx = nx_reg;
    assign ny = ny_reg;

endmodule

[hdl/scc_pipe.sv]
// Six-stage contact datapath: offsets, dot products, side tests, projection, box test.
// Depends on scc_pkg (margin constants); geometry comes from scc_normal_unit.
module scc_pipe #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          hold,
    input  logic signed [COORD_WIDTH-1:0] cur_x,
    input  logic signed [COORD_WIDTH-1:0] cur_y,
    input  logic signed [COORD_WIDTH-1:0] pred_x,
    input  logic signed [COORD_WIDTH-1:0] pred_y,
    input  logic [COORD_WIDTH-2:0]        particle_radius,
    input  logic                          seg_zero,
    input  logic signed [COORD_WIDTH-1:0] sx,
    input  logic signed [COORD_WIDTH-1:0] sy,
    input  logic signed [COORD_WIDTH-1:0] ex,
    input  logic signed [COORD_WIDTH-1:0] ey,
    input  logic signed [COORD_WIDTH-1:0] mx,
    input  logic signed [COORD_WIDTH-1:0] my,
    input  logic signed [FRAC_BITS+2:0]   nx,
    input  logic signed [FRAC_BITS+2:0]   ny,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          contact,
    output logic signed [COORD_WIDTH-1:0] normal_x,
    output logic signed [COORD_WIDTH-1:0] normal_y,
    output logic signed [COORD_WIDTH-1:0] tangent_x,
    output logic signed [COORD_WIDTH-1:0] tangent_y,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y
);
    localparam int CW   = COORD_WIDTH;
    localparam int NW2  = FRAC_BITS + 3;
    localparam int DW   = CW + 1;
    localparam int PW   = DW + NW2;
    localparam int SW   = PW + 1;
    localparam int CMPW = SW + 8;
    localparam int MGW  = CW + 7;
    localparam int SSW  = SW - FRAC_BITS + 1;
    localparam int TPW  = SSW + NW2;
    localparam int QW   = TPW - FRAC_BITS + 1;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] hi, lo;
        hi = QW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
            sat_cw = CW'(hi);
        else if (v < lo)
            sat_cw = CW'(lo);
        else
            sat_cw = CW'(v);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // stage 1
    logic signed [DW-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic [MGW-1:0]        mg1_reg;
    // stage 2
    logic signed [PW-1:0]  pcx_reg, pcy_reg, ppx_reg, ppy_reg, ptx_reg, pty_reg;
    logic [MGW-1:0]        mg2_reg;
    // stage 3
    logic signed [SW-1:0]  dc_reg, dp_reg, dt_reg;
    logic [MGW-1:0]        mg3_reg;
    // stage 4
    logic signed [SSW-1:0] s_reg;
    logic signed [NW2-1:0] tx4_reg, ty4_reg;
    logic                  hit4_reg;
    // stage 5
    logic signed [TPW-1:0] qpx_reg, qpy_reg;
    logic signed [NW2-1:0] tx5_reg, ty5_reg;
    logic                  hit5_reg;
    // stage 6 / output
    logic                  con_reg;
    logic signed [CW-1:0]  nxo_reg, nyo_reg, txo_reg, tyo_reg, qxo_reg, qyo_reg;

    logic signed [CMPW-1:0] margin, dc100, dp100;
    logic                   flip, hit;
    logic signed [SW:0]     dt_f;
    logic signed [QW-1:0]   qx, qy;
    logic signed [CW-1:0]   lox, hix, loy, hiy;
    logic                   in_box;

    // each stage moves when it is empty or its successor moves
    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid && in_ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        margin = CMPW'($signed({1'b0, mg3_reg})) <<< FRAC_BITS;
        dc100  = CMPW'(dc_reg) * CMPW'(scc_pkg::MARGIN_DEN);
        dp100  = CMPW'(dp_reg) * CMPW'(scc_pkg::MARGIN_DEN);
        flip   = (dc100 < margin);
        hit    = flip ? (-dp100 < margin) : (dp100 < margin);
        dt_f   = flip ? -(SW+1)'(dt_reg) : (SW+1)'(dt_reg);
    end

    always_comb
    begin
        qx     = QW'(mx) + QW'(qpx_reg >>> FRAC_BITS);
        qy     = QW'(my) + QW'(qpy_reg >>> FRAC_BITS);
        lox    = (sx < ex) ? sx : ex;
        hix    = (sx < ex) ? ex : sx;
        loy    = (sy < ey) ? sy : ey;
        hiy    = (sy < ey) ? ey : sy;
        in_box = (qx >= QW'(lox)) && (qx <= QW'(hix)) && (qy >= QW'(loy)) && (qy <= QW'(hiy));
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ax_reg  <= DW'(cur_x) - DW'(mx);
            ay_reg  <= DW'(cur_y) - DW'(my);
            bx_reg  <= DW'(pred_x) - DW'(mx);
            by_reg  <= DW'(pred_y) - DW'(my);
            mg1_reg <= MGW'(particle_radius) * MGW'(scc_pkg::MARGIN_NUM);
        end
        if (en2)
        begin
            pcx_reg <= PW'(ax_reg) * PW'(nx);
            pcy_reg <= PW'(ay_reg) * PW'(ny);
            ppx_reg <= PW'(bx_reg) * PW'(nx);
            ppy_reg <= PW'(by_reg) * PW'(ny);
            ptx_reg <= PW'(bx_reg) * PW'(ny);
            pty_reg <= PW'(by_reg) * PW'(nx);
            mg2_reg <= mg1_reg;
        end
        if (en3)
        begin
            dc_reg  <= SW'(pcx_reg) + SW'(pcy_reg);
            dp_reg  <= SW'(ppx_reg) + SW'(ppy_reg);
            dt_reg  <= SW'(ptx_reg) - SW'(pty_reg);
            mg3_reg <= mg2_reg;
        end
        if (en4)
        begin
            s_reg    <= SSW'(dt_f >>> FRAC_BITS);
            tx4_reg  <= flip ? -ny : ny;
            ty4_reg  <= flip ? nx : -nx;
            hit4_reg <= hit;
        end
        if (en5)
        begin
            qpx_reg  <= TPW'(s_reg) * TPW'(tx4_reg);
            qpy_reg  <= TPW'(s_reg) * TPW'(ty4_reg);
            tx5_reg  <= tx4_reg;
            ty5_reg  <= ty4_reg;
            hit5_reg <= hit4_reg;
        end
        if (en6)
        begin
            con_reg <= hit5_reg && in_box && !seg_zero;
            if (hit5_reg && in_box && !seg_zero)
            begin
                // tangent is (ny, -nx) or its negation, so the normal comes back out of it
                nxo_reg <= sat_cw(QW'(-ty5_reg));
                nyo_reg <= sat_cw(QW'(tx5_reg));
                txo_reg <= sat_cw(QW'(tx5_reg));
                tyo_reg <= sat_cw(QW'(ty5_reg));
                qxo_reg <= sat_cw(qx);
                qyo_reg <= sat_cw(qy);
            end
            else
            begin
                nxo_reg <= '0;
                nyo_reg <= '0;
                txo_reg <= '0;
                tyo_reg <= '0;
                qxo_reg <= '0;
                qyo_reg <= '0;
            end
        end
    end

    assign out_valid = v6_reg;
    assign contact   = con_reg;
    assign normal_x  = nxo_reg;
    assign normal_y  = nyo_reg;
    assign tangent_x = txo_reg;
    assign tangent_y = tyo_reg;
    assign point_x   = qxo_reg;
    assign point_y   = qyo_reg;

endmodule

[hdl/segment_contact_check.sv]
// Top level of the particle / line segment contact checker.
// Depends on scc_pkg, scc_normal_unit and scc_pipe.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: cur_x, cur_y, pred_x, pred_y, particle_radius
//  m_*       out  m_tvalid/m_tready  m_tdata: normal, tangent, point; m_tuser: contact
//  cfg_*     in   cfg_we             cfg_index, cfg_data (segment end points)
//
// One beat per cycle in, one out, while the normal unit is idle and m_tready is high.
// After reset and after every configuration write the normal unit runs its
// normalize / square-root / divide sequence (only the load step for a
// zero-length segment), and s_tready stays low during it.
// A stalled output holds each full stage that has only full stages after it.
module segment_contact_check #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // cur_x, cur_y, pred_x, pred_y, particle_radius, zero fill
    input  logic [((5*COORD_WIDTH-1+7)/8)*8-1:0]      s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // normal_x, normal_y, tangent_x, tangent_y, point_x, point_y, zero fill
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // contact
    output logic [0:0]                                m_tuser,
    input  logic                                      cfg_we,
    input  logic [1:0]                                cfg_index,
    input  logic [COORD_WIDTH-1:0]                    cfg_data
);
    localparam int CW  = COORD_WIDTH;
    localparam int OTW = ((6*CW+7)/8)*8;

    logic                   busy, seg_zero, contact;
    logic signed [CW-1:0]   sx, sy, ex, ey, mx, my;
    logic signed [FRAC_BITS+2:0] nx, ny;
    logic signed [CW-1:0]   normal_x, normal_y, tangent_x, tangent_y, point_x, point_y;

    scc_normal_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_normal (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .busy     (busy),
        .seg_zero (seg_zero),
        .sx       (sx),
        .sy       (sy),
        .ex       (ex),
        .ey       (ey),
        .mx       (mx),
        .my       (my),
        .nx       (nx),
        .ny       (ny)
    );

    scc_pipe #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .hold           (busy),
        .cur_x          (s_tdata[CW-1:0]),
        .cur_y          (s_tdata[2*CW-1:CW]),
        .pred_x         (s_tdata[3*CW-1:2*CW]),
        .pred_y         (s_tdata[4*CW-1:3*CW]),
        .particle_radius(s_tdata[5*CW-2:4*CW]),
        .seg_zero       (seg_zero),
        .sx             (sx),
        .sy             (sy),
        .ex             (ex),
        .ey             (ey),
        .mx             (mx),
        .my             (my),
        .nx             (nx),
        .ny             (ny),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .contact        (contact),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .tangent_x      (tangent_x),
        .tangent_y      (tangent_y),
        .point_x        (point_x),
        .point_y        (point_y)
    );

    assign m_tdata = OTW'({point_y, point_x, tangent_y, tangent_x, normal_y, normal_x});
    assign m_tuser = contact;

    // never take a beat while the normal is being rebuilt
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("beat accepted while normal unit busy");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("non-zero payload without contact");

    // tangent is the normal turned a quarter
    a_tangent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (tangent_x == normal_y))
        else $error("tangent_x differs from normal_y");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("configuration write did not restart the normal unit");

endmodule
